@@ rtl/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation unit.
// No dependencies; used by mexp_ctrl, mexp_dp and modular_exponentiation_unit.
package mexp_pkg;

  localparam int unsigned FIELD_W      = 31;  // base and power_mod width
  localparam int unsigned DEF_EXP_BITS = 31;
  localparam int unsigned DEF_MOD_BITS = 31;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  // operand selection for the shift-add modular multiplier
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_REDUCE = 2'd0;  // base * 1 mod m
  localparam logic [OP_W-1:0] OP_SQUARE = 2'd1;  // p * p mod m
  localparam logic [OP_W-1:0] OP_MULT   = 2'd2;  // p * base mod m

  typedef struct packed {
    logic            op_start;   // load operands, clear product, load step count
    logic [OP_W-1:0] op_sel;
    logic            op_step;    // one shift-add-reduce step
    logic            red_done;   // latch reduced base, seed product, top exponent bit
    logic            eidx_dec;   // move to next lower exponent bit
    logic            out_load;   // capture result into output register
  } mexp_cmd_t;

  typedef struct packed {
    logic e_zero;     // exponent register is zero
    logic m_zero;     // modulus register is zero
    logic ebit;       // exponent bit at current index
    logic eidx_zero;  // current index is bit 0
    logic op_last;    // last step of the running operation
  } mexp_sts_t;

endpackage

@@ rtl/mexp_ctrl.sv @@
// Sequencer for the modular exponentiation unit: handshakes and step order.
// Depends on mexp_pkg; drives mexp_dp through mexp_cmd_t.
module mexp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mexp_pkg::mexp_sts_t sts_i,
  output mexp_pkg::mexp_cmd_t cmd_o
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_BIT  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_SQD  = 3'd5;
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       started_q, started_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    cmd_o     = '0;
    cmd_o.op_sel = OP_REDUCE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.e_zero || sts_i.m_zero) begin
            state_d = S_FIN;
          end else begin
            cmd_o.op_start = 1'b1;
            cmd_o.op_sel   = OP_REDUCE;
            state_d        = S_RED;
          end
        end
      end
      S_RED: begin
        cmd_o.op_step = 1'b1;
        if (sts_i.op_last) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.red_done = 1'b1;
        started_d      = 1'b0;
        state_d        = S_BIT;
      end
      S_BIT: begin
        // leading zero bits of the exponent are skipped one per cycle
        if (!started_q && !sts_i.ebit) begin
          if (sts_i.eidx_zero) begin
            state_d = S_FIN;
          end else begin
            cmd_o.eidx_dec = 1'b1;
          end
        end else begin
          started_d      = 1'b1;
          cmd_o.op_start = 1'b1;
          cmd_o.op_sel   = OP_SQUARE;
          state_d        = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.op_sel  = OP_SQUARE;
        cmd_o.op_step = 1'b1;
        if (sts_i.op_last) state_d = S_SQD;
      end
      S_SQD: begin
        if (sts_i.ebit) begin
          cmd_o.op_start = 1'b1;
          cmd_o.op_sel   = OP_MULT;
          state_d        = S_MUL;
        end else if (sts_i.eidx_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.eidx_dec = 1'b1;
          state_d        = S_BIT;
        end
      end
      S_MUL: begin
        cmd_o.op_sel  = OP_MULT;
        cmd_o.op_step = 1'b1;
        if (sts_i.op_last) begin
          if (sts_i.eidx_zero) begin
            state_d = S_FIN;
          end else begin
            cmd_o.eidx_dec = 1'b1;
            state_d        = S_BIT;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/mexp_dp.sv @@
// Datapath of the modular exponentiation unit: config registers, the
// shift-add modular multiplier, exponent bit index and output register.
// Depends on mexp_pkg; commanded by mexp_ctrl.
module mexp_dp #(
  parameter int unsigned EXP_BITS = mexp_pkg::DEF_EXP_BITS,
  parameter int unsigned MOD_BITS = mexp_pkg::DEF_MOD_BITS,
  parameter int unsigned CFG_W    = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]                cfg_data_i,
  input  logic [mexp_pkg::FIELD_W-1:0]    base_i,
  output logic [mexp_pkg::FIELD_W-1:0]    power_mod_o,
  input  mexp_pkg::mexp_cmd_t             cmd_i,
  output mexp_pkg::mexp_sts_t             sts_o
);
  import mexp_pkg::*;

  // multiplier operand width: covers the raw base and any residue
  localparam int unsigned YW  = (FIELD_W > MOD_BITS) ? FIELD_W : MOD_BITS;
  localparam int unsigned CNW = $clog2(YW + 1);
  localparam int unsigned EIW = $clog2(EXP_BITS);
  localparam int unsigned TW  = MOD_BITS + 3;

  logic [EXP_BITS-1:0] exp_q;
  logic [MOD_BITS-1:0] mod_q;
  logic [MOD_BITS-1:0] bm_q;      // base mod m
  logic [MOD_BITS-1:0] p_q, p_d;  // running product / accumulator
  logic [MOD_BITS-1:0] x_q;
  logic [YW-1:0]       y_q;
  logic [CNW-1:0]      cnt_q;
  logic [EIW-1:0]      eidx_q;
  logic [FIELD_W-1:0]  out_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      mod_q <= MOD_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXPONENT: exp_q <= cfg_data_i[EXP_BITS-1:0];
        REG_MODULUS:  mod_q <= cfg_data_i[MOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // one step: p = (2p + ybit*x) mod m, with 2p + x < 3m
  logic [TW-1:0] t, d1, d2;
  always_comb begin
    t  = (TW'(p_q) << 1) + (y_q[YW-1] ? TW'(x_q) : '0);
    d1 = t - TW'(mod_q);
    d2 = t - (TW'(mod_q) << 1);
    if (!d2[TW-1]) begin
      p_d = d2[MOD_BITS-1:0];
    end else if (!d1[TW-1]) begin
      p_d = d1[MOD_BITS-1:0];
    end else begin
      p_d = t[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_start) begin
      p_q   <= '0;
      cnt_q <= CNW'(YW);
      case (cmd_i.op_sel)
        OP_REDUCE: begin
          x_q <= MOD_BITS'(1);
          y_q <= YW'(base_i);
        end
        OP_SQUARE: begin
          x_q <= p_q;
          y_q <= YW'(p_q);
        end
        OP_MULT: begin
          x_q <= p_q;
          y_q <= YW'(bm_q);
        end
        default: begin
          x_q <= '0;
          y_q <= '0;
        end
      endcase
    end else if (cmd_i.op_step) begin
      p_q   <= p_d;
      y_q   <= y_q << 1;
      cnt_q <= cnt_q - CNW'(1);
    end else if (cmd_i.red_done) begin
      bm_q <= p_q;
      // accumulator starts at 1 mod m
      p_q  <= (mod_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.red_done) begin
      eidx_q <= EIW'(EXP_BITS - 1);
    end else if (cmd_i.eidx_dec) begin
      eidx_q <= eidx_q - EIW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (exp_q == '0) begin
        out_q <= FIELD_W'(1);
      end else if (mod_q == '0) begin
        out_q <= '0;
      end else begin
        out_q <= FIELD_W'(p_q);
      end
    end
  end

  assign power_mod_o     = out_q;
  assign sts_o.e_zero    = (exp_q == '0);
  assign sts_o.m_zero    = (mod_q == '0);
  assign sts_o.ebit      = exp_q[eidx_q];
  assign sts_o.eidx_zero = (eidx_q == '0);
  assign sts_o.op_last   = (cnt_q == CNW'(1));

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// Top level of the modular exponentiation unit (left-to-right square-and-multiply).
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
//
//  channel    | handshake                               | payload
//  -----------+-----------------------------------------+---------------------
//  config     | cfg_we_i (write when high)              | cfg_idx_i, cfg_data_i
//  base in    | base_valid_i / base_ready_o             | base_i
//  result out | power_mod_valid_o / power_mod_ready_i   | power_mod_o
//
// One multiplier operation takes YW steps, YW = max(31, MOD_BITS), one step a
// cycle in the shared shift-add reducer. An item first reduces the base mod m,
// skips the leading zero exponent bits, then squares for every bit from the top
// set bit down and multiplies by the reduced base for every set bit.
// A zero exponent or zero modulus skips the multiplier and goes straight to the end.
// Reset clears the sequencer and output valid; exponent resets to 0, modulus to 1.
// The output register holds a finished result while the next item is accepted
// and worked on; the sequencer waits at the end only if that result is still
// not taken.
module modular_exponentiation_unit #(
  parameter int unsigned EXP_BITS = mexp_pkg::DEF_EXP_BITS,
  parameter int unsigned MOD_BITS = mexp_pkg::DEF_MOD_BITS,
  parameter int unsigned CFG_W    = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic                           base_valid_i,
  output logic                           base_ready_o,
  input  logic [mexp_pkg::FIELD_W-1:0]   base_i,
  output logic                           power_mod_valid_o,
  input  logic                           power_mod_ready_i,
  output logic [mexp_pkg::FIELD_W-1:0]   power_mod_o
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  // sequencer: handshakes and order of reduce / square / multiply
  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (base_valid_i),
    .in_ready_o  (base_ready_o),
    .out_valid_o (power_mod_valid_o),
    .out_ready_i (power_mod_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // registers, modular multiplier and result register
  mexp_dp #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS),
    .CFG_W    (CFG_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .base_i      (base_i),
    .power_mod_o (power_mod_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ dv/modular_exponentiation_unit_tb.sv @@
// Self-checking testbench for modular_exponentiation_unit (base^exponent mod modulus).
// Depends on mexp_pkg and the RTL of modular_exponentiation_unit; standalone otherwise.
// Directed table first, then random phases with new exponent/modulus each phase.
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  localparam int unsigned EXP_W = DEF_EXP_BITS;
  localparam int unsigned MOD_W = DEF_MOD_BITS;
  localparam int unsigned CFG_W = (EXP_W > MOD_W) ? EXP_W : MOD_W;

  // random part: phases of items, each phase under its own key
  localparam int N_PHASES       = 14;
  localparam int ITEMS_PER_PHASE = 19;
  localparam int PRESSURE_PHASE = 2;

  // limits sized above one item with a full 31-bit exponent; the receiver's
  // long hold-off and the longest sender gap come on top of that
  localparam int LONG_HOLD   = 3000;
  localparam int DRAIN_WAIT  = 2200;
  localparam int STALL_LIMIT = 40000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 base_valid_i;
  logic                 base_ready_o;
  logic [FIELD_W-1:0]   base_i;
  logic                 power_mod_valid_o;
  logic                 power_mod_ready_i;
  logic [FIELD_W-1:0]   power_mod_o;

  modular_exponentiation_unit #(
    .EXP_BITS(EXP_W),
    .MOD_BITS(MOD_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .base_valid_i     (base_valid_i),
    .base_ready_o     (base_ready_o),
    .base_i           (base_i),
    .power_mod_valid_o(power_mod_valid_o),
    .power_mod_ready_i(power_mod_ready_i),
    .power_mod_o      (power_mod_o)
  );

  always #10 clk_i = ~clk_i;

  // TB's own copy of the key registers, tracks what has been written
  logic [EXP_W-1:0] exp_cfg;
  logic [MOD_W-1:0] mod_cfg;

  // expected power_mod values, oldest first
  logic [FIELD_W-1:0] power_mod_due [$];
  logic [FIELD_W-1:0] due_head;
  int                 mismatch_cnt = 0;

  bit no_gaps   = 1'b0;  // both sides run back to back while set
  bit hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int stall_cnt = 0;

  // Directed table. Rows whose answer is obvious carry it; the rest go
  // through the predictor. A row whose key differs from the current one
  // drains the block and rewrites the key first.
  typedef struct packed {
    logic [EXP_W-1:0]   exp_val;
    logic [MOD_W-1:0]   mod_val;
    logic [FIELD_W-1:0] base;
    logic               known;
    logic [FIELD_W-1:0] answer;
  } key_row_t;

  localparam int N_ROWS = 21;
  key_row_t key_rows [N_ROWS] = '{
    // key as it comes out of reset: exponent 0 gives 1
    '{31'h0,        31'h1,        31'h0,        1'b1, 31'h1},
    '{31'h0,        31'h1,        31'h7FFFFFFF, 1'b1, 31'h1},
    // zero exponent wins even over a zero modulus
    '{31'h0,        31'h0,        31'h12345678, 1'b1, 31'h1},
    '{31'h0,        31'h7FFFFFFF, 31'h5,        1'b1, 31'h1},
    // zero modulus with nonzero exponent gives 0
    '{31'h5,        31'h0,        31'h3,        1'b1, 31'h0},
    '{31'h7FFFFFFF, 31'h0,        31'h7FFFFFFF, 1'b1, 31'h0},
    // modulus 1: everything is 0
    '{31'h7FFFFFFF, 31'h1,        31'h0,        1'b1, 31'h0},
    '{31'h1,        31'h1,        31'h7FFFFFFF, 1'b1, 31'h0},
    // base equal to the modulus reduces to 0
    '{31'h1,        31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 31'h0},
    '{31'h1,        31'h7FFFFFFF, 31'h7FFFFFFE, 1'b1, 31'h7FFFFFFE},
    '{31'h1,        31'h7FFFFFFF, 31'h0,        1'b1, 31'h0},
    '{31'h1,        31'h7FFFFFFE, 31'h7FFFFFFF, 1'b1, 31'h1},
    '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h0,        1'b1, 31'h0},
    '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1,        1'b1, 31'h1},
    // longest scans, predicted
    '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h2,        1'b0, 31'h0},
    '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFE, 1'b0, 31'h0},
    '{31'h40000000, 31'h7FFFFFFF, 31'h3,        1'b0, 31'h0},
    // small textbook key
    '{31'd2753,     31'd3233,     31'd2790,     1'b0, 31'h0},
    '{31'h2,        31'h2,        31'h3,        1'b0, 31'h0},
    '{31'h55555555, 31'h2AAAAAAB, 31'h2AAAAAAA, 1'b0, 31'h0},
    '{31'h2AAAAAAA, 31'h55555555, 31'h55555554, 1'b0, 31'h0}
  };

  // base^e mod m, left to right from the top set exponent bit
  function automatic logic [FIELD_W-1:0] power_mod_of(input logic [FIELD_W-1:0] b,
                                                      input logic [EXP_W-1:0] e,
                                                      input logic [MOD_W-1:0] m);
    bit [63:0] acc;
    bit [63:0] bred;
    bit [63:0] mw;
    int        top;
    int        i;
    if (e == '0) return FIELD_W'(1);
    if (m == '0) return '0;
    mw   = 64'(m);
    bred = 64'(b) % mw;
    acc  = 64'd1 % mw;
    top  = 0;
    for (i = 0; i < EXP_W; i++)
      if (e[i]) top = i;
    for (i = top; i >= 0; i--) begin
      acc = (acc * acc) % mw;
      if (e[i]) acc = (acc * bred) % mw;
    end
    return acc[FIELD_W-1:0];
  endfunction

  // mostly back to back, often a few cycles, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_base(input logic [MOD_W-1:0] m);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return FIELD_W'(m);
      3:       return FIELD_W'(m - 1'b1);
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return EXP_W'($urandom_range(1, 255));
      4, 5:    return EXP_W'($urandom_range(256, 65535));
      6:       return '1;
      default: return EXP_W'($urandom());
    endcase
  endfunction

  function automatic logic [MOD_W-1:0] pick_modulus();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return MOD_W'(1);
      2, 3:    return MOD_W'($urandom_range(2, 1000));
      4:       return '1;
      5:       return MOD_W'(1) << $urandom_range(1, MOD_W - 1);
      default: return MOD_W'($urandom());
    endcase
  endfunction

  // Offers one base item and waits for it to be taken. Entered and left
  // at a falling edge; valid only drops when a gap actually follows.
  task automatic push_base(input logic [FIELD_W-1:0] b, input logic known,
                           input logic [FIELD_W-1:0] answer);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      base_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    base_valid_i <= 1'b1;
    base_i       <= b;
    do @(posedge clk_i); while (!base_ready_o);
    power_mod_due.push_back(known ? answer : power_mod_of(b, exp_cfg, mod_cfg));
    @(negedge clk_i);
  endtask

  // stop offering and wait until every outstanding result has come out
  task automatic drain();
    base_valid_i <= 1'b0;
    while (power_mod_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // rewrites only what changed; caller has drained the block
  task automatic set_key(input logic [EXP_W-1:0] e, input logic [MOD_W-1:0] m);
    bit wrote;
    wrote = 1'b0;
    if (e != exp_cfg) begin
      write_reg(REG_EXPONENT, CFG_W'(e));
      exp_cfg = e;
      wrote   = 1'b1;
    end
    if (m != mod_cfg) begin
      write_reg(REG_MODULUS, CFG_W'(m));
      mod_cfg = m;
      wrote   = 1'b1;
    end
    if (wrote) cfg_we_i <= 1'b0;
  endtask

  // Result side: ready with random stalls, plus one long hold-off on request
  // so the output register stays full and the input backs up.
  initial begin : result_sink
    int stall_left;
    stall_left        = 0;
    power_mod_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        power_mod_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        power_mod_ready_i <= 1'b0;
      end else begin
        power_mod_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // checker: every taken result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && power_mod_valid_o && power_mod_ready_i) begin
      if (power_mod_due.size() == 0) begin
        $error("power_mod: no item outstanding, got %h", power_mod_o);
        mismatch_cnt++;
      end else begin
        due_head = power_mod_due.pop_front();
        if (power_mod_o !== due_head) begin
          $error("power_mod: expected %h, actual %h", due_head, power_mod_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog: too long with no item moving on any channel ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (base_valid_i && base_ready_o) ||
        (power_mod_valid_o && power_mod_ready_i)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int row;
    int phase;
    int n;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_EXPONENT;
    cfg_data_i   = '0;
    base_valid_i = 1'b0;
    base_i       = '0;
    exp_cfg      = '0;        // reset key: exponent 0, modulus 1
    mod_cfg      = MOD_W'(1);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows
    for (row = 0; row < N_ROWS; row++) begin
      if (key_rows[row].exp_val != exp_cfg || key_rows[row].mod_val != mod_cfg) begin
        drain();
        set_key(key_rows[row].exp_val, key_rows[row].mod_val);
      end
      push_base(key_rows[row].base, key_rows[row].known, key_rows[row].answer);
    end

    // random phases, a fresh key for each
    for (phase = 0; phase < N_PHASES; phase++) begin
      drain();
      if (phase == PRESSURE_PHASE) begin
        // short exponent: items finish fast and pile up behind the hold-off
        set_key(EXP_W'($urandom_range(2, 40)), pick_modulus() | MOD_W'(2));
        hold_req = 1'b1;
      end else begin
        set_key(pick_exponent(), pick_modulus());
      end
      no_gaps = (phase % 4 == 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        push_base(pick_base(mod_cfg), 1'b0, '0);
    end
    no_gaps = 1'b0;

    drain();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatch_cnt == 0 && power_mod_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
